FILE: hdl/modexp_pkg.sv
// modexp_pkg: shared constants and types for the modular exponentiation core
// holds word width, register defaults, controller state and command/status structs
// no dependencies

package modexp_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int CNT_W      = $clog2(WORD_WIDTH);
    localparam int KEEP_W     = 4;
    localparam int CFG_IDX_W  = 1;

    localparam logic [WORD_WIDTH-1:0] MODULUS_RST  = WORD_WIDTH'(6103297);
    localparam logic [WORD_WIDTH-1:0] EXPONENT_RST = WORD_WIDTH'(65537);

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_RED,
        ST_CHECK,
        ST_MRES,
        ST_SQR,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MSRC_RED,
        MSRC_MRES,
        MSRC_SQR
    } t_mul_src;

    typedef struct packed {
        logic     load;       // capture input transaction and live config
        logic     mul_start;
        t_mul_src mul_src;
        logic     wr_a;       // base <= multiplier result
        logic     wr_res;     // result <= multiplier result
        logic     res_one;
        logic     res_zero;
        logic     exp_shift;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic mod_zero;
        logic exp_zero;
        logic exp_lsb;
    } t_dp_sts;

endpackage

FILE: hdl/modular_exponentiation_core.sv
// Modular exponentiation core: result = message ^ exponent mod modulus, 32-bit words.
// Input channel (i_in_valid/o_in_ready) takes a word with stream sideband bits;
// output channel (o_out_valid/i_out_ready) returns one result per input with the
// sideband copied. Config port (i_cfg_we, i_cfg_index, i_cfg_data): index 0 is
// the modulus (reset 6103297), index 1 the exponent (reset 65537); write only
// while the core is idle. One transaction at a time. The base is first
// reduced, then each exponent bit up to the highest set one costs a square and,
// when set, a multiply. Every modular multiply runs on one bit-serial unit doing
// one double or one add per cycle. The core returns to idle, ready for the next
// transaction, in the same state update that raises o_out_valid. A modulus of
// zero skips the math and presents 0. Reset (synchronous, active low) returns the
// core to idle, drops o_out_valid and restores the register defaults. The result
// sits in an output register: a new transaction is accepted while it waits, and
// a stalled receiver only holds the core once the next result is finished.
// depends on modexp_pkg, modexp_ctrl, modexp_datapath

module modular_exponentiation_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [modexp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [modexp_pkg::WORD_WIDTH-1:0]  i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [modexp_pkg::WORD_WIDTH-1:0]  i_message_word,
    input  logic [modexp_pkg::KEEP_W-1:0]      i_in_keep,
    input  logic [modexp_pkg::KEEP_W-1:0]      i_in_strobe,
    input  logic                               i_in_user,
    input  logic                               i_in_last,
    input  logic                               i_in_id,
    input  logic                               i_in_dest,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [modexp_pkg::WORD_WIDTH-1:0]  o_result_word,
    output logic [modexp_pkg::KEEP_W-1:0]      o_out_keep,
    output logic [modexp_pkg::KEEP_W-1:0]      o_out_strobe,
    output logic                               o_out_user,
    output logic                               o_out_last,
    output logic                               o_out_id,
    output logic                               o_out_dest
);

    modexp_pkg::t_dp_cmd w_cmd;
    modexp_pkg::t_dp_sts w_sts;

    modexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    modexp_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_message_word (i_message_word),
        .i_in_keep      (i_in_keep),
        .i_in_strobe    (i_in_strobe),
        .i_in_user      (i_in_user),
        .i_in_last      (i_in_last),
        .i_in_id        (i_in_id),
        .i_in_dest      (i_in_dest),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_result_word  (o_result_word),
        .o_out_keep     (o_out_keep),
        .o_out_strobe   (o_out_strobe),
        .o_out_user     (o_out_user),
        .o_out_last     (o_out_last),
        .o_out_id       (o_out_id),
        .o_out_dest     (o_out_dest)
    );

endmodule

FILE: hdl/modexp_datapath.sv
// modexp_datapath: config registers, operand registers, bit-serial modular
// multiplier and output register of the modular exponentiation core
// depends on modexp_pkg

module modexp_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [modexp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [modexp_pkg::WORD_WIDTH-1:0]  i_cfg_data,
    input  logic [modexp_pkg::WORD_WIDTH-1:0]  i_message_word,
    input  logic [modexp_pkg::KEEP_W-1:0]      i_in_keep,
    input  logic [modexp_pkg::KEEP_W-1:0]      i_in_strobe,
    input  logic                               i_in_user,
    input  logic                               i_in_last,
    input  logic                               i_in_id,
    input  logic                               i_in_dest,
    input  modexp_pkg::t_dp_cmd                i_cmd,
    output modexp_pkg::t_dp_sts                o_sts,
    output logic [modexp_pkg::WORD_WIDTH-1:0]  o_result_word,
    output logic [modexp_pkg::KEEP_W-1:0]      o_out_keep,
    output logic [modexp_pkg::KEEP_W-1:0]      o_out_strobe,
    output logic                               o_out_user,
    output logic                               o_out_last,
    output logic                               o_out_id,
    output logic                               o_out_dest
);

    localparam int W = modexp_pkg::WORD_WIDTH;

    // (a + b) mod n for a, b < n
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] a,
                                             input logic [W-1:0] b,
                                             input logic [W-1:0] n);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, n}) begin
            s = s - {1'b0, n};
        end
        return s[W-1:0];
    endfunction

    logic [W-1:0] r_cfg_mod;
    logic [W-1:0] r_cfg_exp;

    logic [W-1:0] r_mod;
    logic [W-1:0] r_exp;
    logic [W-1:0] r_msg;
    logic [W-1:0] r_a;
    logic [W-1:0] r_res;
    logic [modexp_pkg::KEEP_W-1:0] r_keep;
    logic [modexp_pkg::KEEP_W-1:0] r_strb;
    logic [3:0]   r_side;

    logic [W-1:0]                  r_acc;
    logic [W-1:0]                  r_mcand;
    logic [W-1:0]                  r_mplier;
    logic [modexp_pkg::CNT_W-1:0]  r_cnt;
    logic                          r_phase;
    logic                          r_run;
    logic                          r_done;

    logic [W-1:0] r_out_word;
    logic [modexp_pkg::KEEP_W-1:0] r_out_keep;
    logic [modexp_pkg::KEEP_W-1:0] r_out_strb;
    logic [3:0]   r_out_side;

    logic [W-1:0] n_mcand;
    logic [W-1:0] n_mplier;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mod <= modexp_pkg::MODULUS_RST;
            r_cfg_exp <= modexp_pkg::EXPONENT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                modexp_pkg::CFG_MODULUS:  r_cfg_mod <= i_cfg_data;
                modexp_pkg::CFG_EXPONENT: r_cfg_exp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // operand select for a new multiply
    always_comb begin
        unique case (i_cmd.mul_src)
            modexp_pkg::MSRC_RED: begin
                // base mod n as 1 * base mod n, horner over the base bits
                n_mcand  = (r_mod == W'(1)) ? '0 : W'(1);
                n_mplier = r_msg;
            end
            modexp_pkg::MSRC_MRES: begin
                n_mcand  = r_res;
                n_mplier = r_a;
            end
            modexp_pkg::MSRC_SQR: begin
                n_mcand  = r_a;
                n_mplier = r_a;
            end
            default: begin
                n_mcand  = r_a;
                n_mplier = r_a;
            end
        endcase
    end

    // shift-and-add modular multiplier: double in phase 0, add in phase 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.mul_start) begin
                r_run   <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= '0;
            end else if (r_run) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == modexp_pkg::CNT_W'(W - 1)) begin
                        r_run  <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_acc    <= '0;
            r_mcand  <= n_mcand;
            r_mplier <= n_mplier;
        end else if (r_run) begin
            if (!r_phase) begin
                r_acc <= add_mod(r_acc, r_acc, r_mod);
            end else begin
                if (r_mplier[W-1]) begin
                    r_acc <= add_mod(r_acc, r_mcand, r_mod);
                end
                r_mplier <= {r_mplier[W-2:0], 1'b0};
            end
        end
    end

    // operand and sideband registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mod  <= r_cfg_mod;
            r_exp  <= r_cfg_exp;
            r_msg  <= i_message_word;
            r_keep <= i_in_keep;
            r_strb <= i_in_strobe;
            r_side <= {i_in_user, i_in_last, i_in_id, i_in_dest};
        end else if (i_cmd.exp_shift) begin
            r_exp <= {1'b0, r_exp[W-1:1]};
        end
        if (i_cmd.wr_a) begin
            r_a <= r_acc;
        end
        if (i_cmd.res_zero) begin
            r_res <= '0;
        end else if (i_cmd.res_one) begin
            r_res <= W'(1);
        end else if (i_cmd.wr_res) begin
            r_res <= r_acc;
        end
    end

    // output register, held until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_word <= r_res;
            r_out_keep <= r_keep;
            r_out_strb <= r_strb;
            r_out_side <= r_side;
        end
    end

    assign o_sts.mul_done = r_done;
    assign o_sts.mod_zero = (r_mod == '0);
    assign o_sts.exp_zero = (r_exp == '0);
    assign o_sts.exp_lsb  = r_exp[0];

    assign o_result_word = r_out_word;
    assign o_out_keep    = r_out_keep;
    assign o_out_strobe  = r_out_strb;
    assign o_out_user    = r_out_side[3];
    assign o_out_last    = r_out_side[2];
    assign o_out_id      = r_out_side[1];
    assign o_out_dest    = r_out_side[0];

endmodule

FILE: hdl/modexp_ctrl.sv
// modexp_ctrl: sequencer for right-to-left square-and-multiply
// drives datapath commands and the input/output handshakes; depends on modexp_pkg

module modexp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  modexp_pkg::t_dp_sts  i_sts,
    output modexp_pkg::t_dp_cmd  o_cmd
);

    modexp_pkg::t_state r_state;
    modexp_pkg::t_state n_state;
    logic               r_out_valid;
    logic               n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= modexp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.mul_src = modexp_pkg::MSRC_SQR;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            modexp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = modexp_pkg::ST_PREP;
                end
            end
            modexp_pkg::ST_PREP: begin
                if (i_sts.mod_zero) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = modexp_pkg::ST_DONE;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_src   = modexp_pkg::MSRC_RED;
                    n_state         = modexp_pkg::ST_RED;
                end
            end
            modexp_pkg::ST_RED: begin
                if (i_sts.mul_done) begin
                    o_cmd.wr_a    = 1'b1;
                    o_cmd.res_one = 1'b1;
                    n_state       = modexp_pkg::ST_CHECK;
                end
            end
            modexp_pkg::ST_CHECK: begin
                priority if (i_sts.exp_zero) begin
                    n_state = modexp_pkg::ST_DONE;
                end else if (i_sts.exp_lsb) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_src   = modexp_pkg::MSRC_MRES;
                    n_state         = modexp_pkg::ST_MRES;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    n_state         = modexp_pkg::ST_SQR;
                end
            end
            modexp_pkg::ST_MRES: begin
                if (i_sts.mul_done) begin
                    // result taken from the accumulator before it restarts
                    o_cmd.wr_res    = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    n_state         = modexp_pkg::ST_SQR;
                end
            end
            modexp_pkg::ST_SQR: begin
                if (i_sts.mul_done) begin
                    o_cmd.wr_a      = 1'b1;
                    o_cmd.exp_shift = 1'b1;
                    n_state         = modexp_pkg::ST_CHECK;
                end
            end
            modexp_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = modexp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = modexp_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/modexp_checker.sv
// modexp_checker: port-level assertions for modular_exponentiation_core
// bound to the top level below; depends on modexp_pkg

module modexp_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [modexp_pkg::WORD_WIDTH-1:0]  o_result_word,
    input logic                               o_out_last
);

    // reset empties the output register
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_word)
            && $stable(o_out_last))
        else $error("stalled result changed");

    // one transaction in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("accepted a second transaction while busy");

    // a fresh result means the core has gone back to accepting
    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result presented while core still busy");

    // no result while a new transaction is still being computed
    a_no_result_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !(o_out_valid && !i_out_ready) |=> !o_out_valid)
        else $error("result appeared without computation");

endmodule

bind modular_exponentiation_core modexp_checker u_modexp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_result_word (o_result_word),
    .o_out_last    (o_out_last)
);

FILE: sim/tb_modular_exponentiation_core.sv
// testbench for modular_exponentiation_core: random and directed words checked against
// a square-and-multiply predictor held in a small scoreboard class
// depends on modexp_pkg and the core rtl
`timescale 1ns / 1ps

typedef struct packed {
    logic [modexp_pkg::WORD_WIDTH-1:0] word;
    logic [modexp_pkg::KEEP_W-1:0]     keep;
    logic [modexp_pkg::KEEP_W-1:0]     strobe;
    logic                              user;
    logic                              last;
    logic                              id;
    logic                              dest;
} t_stream_beat;

class modexp_scoreboard;
    localparam int W = modexp_pkg::WORD_WIDTH;

    logic [W-1:0] modulus;
    logic [W-1:0] exponent;
    t_stream_beat result_q[$];
    int           errors;

    function new();
        modulus  = modexp_pkg::MODULUS_RST;
        exponent = modexp_pkg::EXPONENT_RST;
        errors   = 0;
    endfunction

    function void set_reg(logic [modexp_pkg::CFG_IDX_W-1:0] idx, logic [W-1:0] data);
        if (idx == modexp_pkg::CFG_MODULUS) begin
            modulus = data;
        end else if (idx == modexp_pkg::CFG_EXPONENT) begin
            exponent = data;
        end
    endfunction

    // right-to-left square and multiply, products kept exact in 64 bits
    function logic [W-1:0] power_mod(logic [W-1:0] base);
        logic [63:0]  acc;
        logic [63:0]  sq;
        logic [63:0]  n;
        logic [W-1:0] e;
        if (modulus == 0) return '0;
        n   = 64'(modulus);
        acc = 64'd1;
        sq  = 64'(base) % n;
        e   = exponent;
        while (e != 0) begin
            if (e[0]) acc = (acc * sq) % n;
            sq = (sq * sq) % n;
            e  = e >> 1;
        end
        return acc[W-1:0];
    endfunction

    function void note_input(t_stream_beat beat);
        t_stream_beat res;
        res      = beat;
        res.word = power_mod(beat.word);
        result_q.push_back(res);
    endfunction

    function int pending();
        return result_q.size();
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(t_stream_beat got);
        t_stream_beat want;
        if (result_q.size() == 0) begin
            $error("result transaction with nothing outstanding: word %0h", got.word);
            errors++;
            return;
        end
        want = result_q.pop_front();
        compare_field("result_word", 64'(want.word), 64'(got.word));
        compare_field("out_keep", 64'(want.keep), 64'(got.keep));
        compare_field("out_strobe", 64'(want.strobe), 64'(got.strobe));
        compare_field("out_user", 64'(want.user), 64'(got.user));
        compare_field("out_last", 64'(want.last), 64'(got.last));
        compare_field("out_id", 64'(want.id), 64'(got.id));
        compare_field("out_dest", 64'(want.dest), 64'(got.dest));
    endfunction
endclass

module tb_modular_exponentiation_core;

    localparam int W                 = modexp_pkg::WORD_WIDTH;
    localparam int KW                = modexp_pkg::KEEP_W;
    localparam int IW                = modexp_pkg::CFG_IDX_W;
    localparam int RANDOM_ITEMS      = 120;
    localparam int CALM_ITEMS        = 30;
    localparam int DRAIN_CYCLES      = 5000;
    localparam longint LIMIT_CYCLES  = 4_000_000;
    localparam logic [W-1:0] PRIVATE_EXP = W'(2416153);

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [IW-1:0] i_cfg_index;
    logic [W-1:0]  i_cfg_data;
    logic          i_in_valid;
    logic          o_in_ready;
    logic [W-1:0]  i_message_word;
    logic [KW-1:0] i_in_keep;
    logic [KW-1:0] i_in_strobe;
    logic          i_in_user;
    logic          i_in_last;
    logic          i_in_id;
    logic          i_in_dest;
    logic          o_out_valid;
    logic          i_out_ready;
    logic [W-1:0]  o_result_word;
    logic [KW-1:0] o_out_keep;
    logic [KW-1:0] o_out_strobe;
    logic          o_out_user;
    logic          o_out_last;
    logic          o_out_id;
    logic          o_out_dest;

    modexp_scoreboard sb;
    bit               idle_en;
    int unsigned      stall_left;
    longint           cycle_count;

    modular_exponentiation_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_message_word(i_message_word),
        .i_in_keep     (i_in_keep),
        .i_in_strobe   (i_in_strobe),
        .i_in_user     (i_in_user),
        .i_in_last     (i_in_last),
        .i_in_id       (i_in_id),
        .i_in_dest     (i_in_dest),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_word (o_result_word),
        .o_out_keep    (o_out_keep),
        .o_out_strobe  (o_out_strobe),
        .o_out_user    (o_out_user),
        .o_out_last    (o_out_last),
        .o_out_id      (o_out_id),
        .o_out_dest    (o_out_dest)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver back-pressure in random bursts
    always @(negedge i_clk) begin
        if (!idle_en) begin
            stall_left  = 0;
            i_out_ready = 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready = 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left  = $urandom_range(0, 9);
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_stream_beat got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.word   = o_result_word;
            got.keep   = o_out_keep;
            got.strobe = o_out_strobe;
            got.user   = o_out_user;
            got.last   = o_out_last;
            got.id     = o_out_id;
            got.dest   = o_out_dest;
            sb.check_result(got);
        end
    end

    function automatic t_stream_beat make_beat(logic [W-1:0] w, logic [3:0] kp,
                                               logic [3:0] st, bit u, bit l, bit i, bit d);
        t_stream_beat b;
        b.word   = w;
        b.keep   = kp;
        b.strobe = st;
        b.user   = u;
        b.last   = l;
        b.id     = i;
        b.dest   = d;
        return b;
    endfunction

    task automatic send_word(t_stream_beat beat);
        int unsigned gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk) i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_message_word = beat.word;
        i_in_keep      = beat.keep;
        i_in_strobe    = beat.strobe;
        i_in_user      = beat.user;
        i_in_last      = beat.last;
        i_in_id        = beat.id;
        i_in_dest      = beat.dest;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(beat);
    endtask

    task automatic pause_input();
        @(negedge i_clk) i_in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IW-1:0] idx, logic [W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_reg(idx, data);
    endtask

    // registers change only with the core drained
    task automatic set_config(logic [W-1:0] mod_val, logic [W-1:0] exp_val);
        pause_input();
        wait_drained();
        write_reg(modexp_pkg::CFG_MODULUS, mod_val);
        write_reg(modexp_pkg::CFG_EXPONENT, exp_val);
    endtask

    initial begin : stimulus
        logic [W-1:0] mod_val;
        logic [W-1:0] exp_val;
        logic [W-1:0] msg;
        int unsigned  phase_len;
        int unsigned  phase_sent;
        int unsigned  rand_sent;
        int unsigned  pkt_len;
        int unsigned  width;
        bit           broken;
        bit           pkt_id;
        bit           pkt_dest;

        sb             = new();
        cycle_count    = 0;
        stall_left     = 0;
        idle_en        = 1'b1;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_message_word = '0;
        i_in_keep      = '0;
        i_in_strobe    = '0;
        i_in_user      = 1'b0;
        i_in_last      = 1'b0;
        i_in_id        = 1'b0;
        i_in_dest      = 1'b0;
        i_out_ready    = 1'b1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // reset registers, base extremes and sideband corners
        send_word(make_beat('0, 4'hF, 4'hF, 1, 1, 1, 1));
        send_word(make_beat(W'(1), 4'h0, 4'h0, 0, 0, 0, 0));
        send_word(make_beat('1, 4'hF, 4'h0, 0, 1, 0, 1));
        send_word(make_beat(modexp_pkg::MODULUS_RST, 4'h0, 4'hF, 1, 0, 1, 0));
        send_word(make_beat(modexp_pkg::MODULUS_RST - 1, 4'hA, 4'h5, 0, 1, 1, 0));
        set_config(modexp_pkg::MODULUS_RST, PRIVATE_EXP);
        send_word(make_beat(W'(12345), 4'h3, 4'hC, 1, 1, 0, 1));
        send_word(make_beat(modexp_pkg::MODULUS_RST + 1, 4'h5, 4'hA, 0, 0, 1, 1));
        // zero modulus short-circuits to 0
        set_config('0, modexp_pkg::EXPONENT_RST);
        send_word(make_beat('0, 4'h1, 4'h2, 1, 0, 0, 0));
        send_word(make_beat('1, 4'h8, 4'h4, 0, 1, 1, 1));
        // modulus one: 1 only for a zero exponent
        set_config(W'(1), '0);
        send_word(make_beat(W'(7), 4'hC, 4'h3, 1, 1, 0, 0));
        set_config(W'(1), W'(5));
        send_word(make_beat('0, 4'h6, 4'h9, 0, 0, 1, 0));
        send_word(make_beat('1, 4'h9, 4'h6, 1, 1, 0, 1));
        set_config('1, '0);
        send_word(make_beat('0, 4'h7, 4'hE, 0, 1, 0, 0));
        send_word(make_beat('1, 4'hE, 4'h7, 1, 0, 1, 1));
        // widest modulus and exponent, slowest path
        set_config('1, '1);
        send_word(make_beat('1 - 1, 4'hF, 4'hF, 0, 0, 0, 1));
        send_word(make_beat(W'(32'hDEADBEEF), 4'h2, 4'hB, 1, 1, 1, 0));
        set_config(W'(2), W'(1));
        send_word(make_beat('1, 4'h4, 4'h1, 0, 1, 0, 1));
        send_word(make_beat(W'(2), 4'hB, 4'hD, 1, 0, 1, 0));
        set_config(W'(32'h80000000), W'(3));
        send_word(make_beat(W'(32'h7FFFFFFF), 4'hD, 4'h8, 0, 1, 1, 1));

        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 11))
                0:       mod_val = '0;
                1:       mod_val = W'(1);
                2:       mod_val = W'($urandom_range(2, 255));
                3:       mod_val = '1;
                4:       mod_val = modexp_pkg::MODULUS_RST;
                default: mod_val = W'($urandom);
            endcase
            phase_len = $urandom_range(4, 16);
            case ($urandom_range(0, 9))
                0:       exp_val = '0;
                1:       exp_val = modexp_pkg::EXPONENT_RST;
                2:       exp_val = PRIVATE_EXP;
                3: begin
                    exp_val   = W'($urandom);
                    phase_len = 3;
                end
                default: begin
                    width   = $urandom_range(1, 20);
                    exp_val = W'($urandom) >> (W - width);
                end
            endcase
            set_config(mod_val, exp_val);
            idle_en    = (rand_sent < RANDOM_ITEMS - CALM_ITEMS);
            phase_sent = 0;
            while (phase_sent < phase_len && rand_sent < RANDOM_ITEMS) begin
                pkt_len  = $urandom_range(1, 8);
                broken   = ($urandom_range(0, 5) == 0);
                pkt_id   = $urandom_range(0, 1);
                pkt_dest = $urandom_range(0, 1);
                for (int unsigned k = 0; k < pkt_len; k++) begin
                    case ($urandom_range(0, 15))
                        0:       msg = '0;
                        1:       msg = '1;
                        2:       msg = mod_val;
                        3:       msg = mod_val - 1;
                        default: msg = W'($urandom);
                    endcase
                    // broken packets scatter last, id and dest at random
                    if (broken) begin
                        send_word(make_beat(msg, 4'($urandom_range(0, 15)),
                                            4'($urandom_range(0, 15)), $urandom_range(0, 1),
                                            $urandom_range(0, 1), $urandom_range(0, 1),
                                            $urandom_range(0, 1)));
                    end else begin
                        send_word(make_beat(msg, 4'($urandom_range(0, 15)),
                                            4'($urandom_range(0, 15)), $urandom_range(0, 1),
                                            (k == pkt_len - 1), pkt_id, pkt_dest));
                    end
                    rand_sent++;
                    phase_sent++;
                end
            end
        end

        pause_input();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
